// File: sv/fpfa_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Fixed partition allocator package
// Shared constants, operation codes and the control structures that pass
// between the partition store, the fit unit and the sequencer.
// ----------------------------------------------------------------------------
package fpfa_pkg;

   localparam int NUM_PARTS = 16;
   localparam int SIZE_BITS = 16;
   localparam int IDX_BITS  = (NUM_PARTS > 1) ? $clog2(NUM_PARTS) : 1;

   // Fixed field widths of the stream payload
   localparam int OP_BITS   = 3;
   localparam int SLOT_BITS = 4;
   localparam int AMT_BITS  = 16;
   localparam int REQ_DATA_BITS = 24;
   localparam int RSP_DATA_BITS = 24;

   typedef enum logic [OP_BITS-1:0] {
      OP_LOAD  = 3'd0,
      OP_FIRST = 3'd1,
      OP_NEXT  = 3'd2,
      OP_BEST  = 3'd3,
      OP_WORST = 3'd4
   } op_type;

   typedef logic [IDX_BITS-1:0]  idx_type;
   typedef logic [SIZE_BITS-1:0] size_type;

   // Requests from the sequencer to the partition store
   typedef struct packed {
      logic     load_en;
      idx_type  load_idx;
      size_type load_size;
      logic     set_en;
      idx_type  set_idx;
      idx_type  rd_idx;
   } store_ctl_type;

   // Operands for the shared fit unit
   typedef struct packed {
      size_type size;
      logic     used;
      size_type amt;
      op_type   mode;
      logic     found;
      size_type best;
   } fit_in_type;

endpackage
`default_nettype wire

// File: sv/fpfa_store.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Partition store
// Size memory with a registered read port, and the per-partition used marks.
// ----------------------------------------------------------------------------
module fpfa_store (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire fpfa_pkg::store_ctl_type ctl,
   output logic [fpfa_pkg::SIZE_BITS-1:0] rd_size,
   output logic                          rd_used
);
   import fpfa_pkg::*;

   size_type             mem [NUM_PARTS];
   size_type             rd_size_ff;
   logic                 rd_used_ff;
   logic [NUM_PARTS-1:0] used_ff;
   logic [NUM_PARTS-1:0] used_in;

   always_ff @(posedge clock) begin
      if (ctl.load_en) begin
         mem[ctl.load_idx] <= ctl.load_size;
      end
      rd_size_ff <= mem[ctl.rd_idx];
      rd_used_ff <= used_ff[ctl.rd_idx];
   end

   always_comb begin
      used_in = used_ff;
      if (ctl.load_en) begin
         used_in[ctl.load_idx] = 1'b0;
      end
      if (ctl.set_en) begin
         used_in[ctl.set_idx] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff <= '0;
      end else begin
         used_ff <= used_in;
      end
   end

   assign rd_size = rd_size_ff;
   assign rd_used = rd_used_ff;

endmodule
`default_nettype wire

// File: sv/fpfa_fit_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Fit unit
// Shared subtract and compare: decides whether the partition under
// examination fits and whether it beats the candidate held so far.
// ----------------------------------------------------------------------------
module fpfa_fit_unit (
   input  wire fpfa_pkg::fit_in_type       fin,
   output logic                             take,
   output logic [fpfa_pkg::SIZE_BITS-1:0]  rem
);
   import fpfa_pkg::*;

   logic fits;
   logic better;

   always_comb begin
      fits = !fin.used && (fin.size >= fin.amt);
      rem  = fin.size - fin.amt;
      unique case (fin.mode)
         OP_BEST:  better = rem < fin.best;
         OP_WORST: better = rem > fin.best;
         default:  better = 1'b0;
      endcase
      // First and next fit keep the first hit; best and worst fit keep the
      // earliest partition among equals since only a strict win replaces it.
      take = fits && (!fin.found || better);
   end

endmodule
`default_nettype wire

// File: sv/fixed_partition_fit_allocator.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Fixed partition fit allocator
// Partition table with first, next, best and worst fit allocation, searched
// one partition per cycle through a shared fit unit.
// ----------------------------------------------------------------------------
// Channel  Direction  tuser              tdata
// req_     in         operation          slot, amount
// rsp_     out        granted            chosen_slot, leftover
//
// A load transaction returns nothing. An allocate transaction runs from its
// acceptance through one read of the size memory per partition, a last
// compare and the commit of the grant; no new request is taken until the
// commit is done, and the single memory read port sets that pace.
// The commit waits while an earlier response is still held on rsp_.
// Reset clears the used marks and the last grant; sizes must be loaded first.
// ----------------------------------------------------------------------------
module fixed_partition_fit_allocator (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_tvalid,
   output logic                                     req_tready,
   input  wire logic [fpfa_pkg::OP_BITS-1:0]       req_tuser,  // [2:0] operation
   input  wire logic [fpfa_pkg::REQ_DATA_BITS-1:0] req_tdata,  // [3:0] slot, [19:4] amount
   output logic                                     rsp_tvalid,
   input  wire logic                                rsp_tready,
   output logic                                     rsp_tuser,  // [0] granted
   output logic [fpfa_pkg::RSP_DATA_BITS-1:0]      rsp_tdata   // [3:0] chosen_slot,
                                                                // [19:4] leftover
);
   import fpfa_pkg::*;

   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_SCAN   = 4'b0010,
      ST_DRAIN  = 4'b0100,
      ST_COMMIT = 4'b1000
   } state_type;

   state_type              state_ff, state_in;
   op_type                 mode_ff, mode_in;
   size_type               amt_ff, amt_in;
   idx_type                idx_ff, idx_in;
   idx_type                cnt_ff, cnt_in;
   idx_type                idx_d_ff, idx_d_in;
   logic                   rd_valid_ff, rd_valid_in;
   logic                   found_ff, found_in;
   size_type               best_ff, best_in;
   idx_type                pick_ff, pick_in;
   logic [SLOT_BITS-1:0]   last_ff, last_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic                   rsp_granted_ff, rsp_granted_in;
   logic [SLOT_BITS-1:0]   rsp_slot_ff, rsp_slot_in;
   logic [AMT_BITS-1:0]    rsp_left_ff, rsp_left_in;

   op_type                 req_op;
   logic [SLOT_BITS-1:0]   req_slot;
   size_type               req_amt;
   logic                   req_fire;
   logic                   is_alloc;
   logic                   commit_fire;
   idx_type                start_idx;

   store_ctl_type          sctl;
   size_type               rd_size;
   logic                   rd_used;
   fit_in_type             fin;
   logic                   take;
   size_type               rem;

   assign req_op   = op_type'(req_tuser);
   assign req_slot = req_tdata[SLOT_BITS-1:0];
   assign req_amt  = SIZE_BITS'(req_tdata[SLOT_BITS +: AMT_BITS]);
   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign is_alloc   = (req_op == OP_FIRST) || (req_op == OP_NEXT) ||
                       (req_op == OP_BEST)  || (req_op == OP_WORST);
   assign commit_fire = (state_ff == ST_COMMIT) && (!rsp_valid_ff || rsp_tready);

   // A stale last grant beyond the table restarts next fit at partition zero.
   assign start_idx = ((req_op == OP_NEXT) && (32'(last_ff) < NUM_PARTS)) ?
                      IDX_BITS'(last_ff) : '0;

   always_comb begin
      sctl.load_en   = req_fire && (req_op == OP_LOAD) && (32'(req_slot) < NUM_PARTS);
      sctl.load_idx  = IDX_BITS'(req_slot);
      sctl.load_size = req_amt;
      sctl.set_en    = commit_fire && found_ff;
      sctl.set_idx   = pick_ff;
      sctl.rd_idx    = idx_ff;
   end

   fpfa_store u_store (
      .clock   (clock),
      .reset   (reset),
      .ctl     (sctl),
      .rd_size (rd_size),
      .rd_used (rd_used)
   );

   always_comb begin
      fin.size  = rd_size;
      fin.used  = rd_used;
      fin.amt   = amt_ff;
      fin.mode  = mode_ff;
      fin.found = found_ff;
      fin.best  = best_ff;
   end

   fpfa_fit_unit u_fit (
      .fin  (fin),
      .take (take),
      .rem  (rem)
   );

   always_comb begin
      state_in       = state_ff;
      mode_in        = mode_ff;
      amt_in         = amt_ff;
      idx_in         = idx_ff;
      cnt_in         = cnt_ff;
      idx_d_in       = idx_ff;
      rd_valid_in    = 1'b0;
      found_in       = found_ff;
      best_in        = best_ff;
      pick_in        = pick_ff;
      last_in        = last_ff;
      rsp_valid_in   = rsp_valid_ff;
      rsp_granted_in = rsp_granted_ff;
      rsp_slot_in    = rsp_slot_ff;
      rsp_left_in    = rsp_left_ff;

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      // Evaluate the entry read in the previous cycle.
      if (rd_valid_ff && take) begin
         found_in = 1'b1;
         best_in  = rem;
         pick_in  = idx_d_ff;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire && is_alloc) begin
               mode_in  = req_op;
               amt_in   = req_amt;
               idx_in   = start_idx;
               cnt_in   = '0;
               found_in = 1'b0;
               best_in  = '0;
               pick_in  = '0;
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            rd_valid_in = 1'b1;
            idx_in = (idx_ff == IDX_BITS'(NUM_PARTS - 1)) ? '0 : idx_ff + 1'b1;
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == IDX_BITS'(NUM_PARTS - 1)) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            state_in = ST_COMMIT;
         end
         ST_COMMIT: begin
            if (commit_fire) begin
               rsp_valid_in   = 1'b1;
               rsp_granted_in = found_ff;
               if (found_ff) begin
                  rsp_slot_in = SLOT_BITS'(pick_ff);
                  rsp_left_in = AMT_BITS'(best_ff);
                  last_in     = SLOT_BITS'(pick_ff);
               end else begin
                  rsp_slot_in = '0;
                  rsp_left_in = '0;
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rd_valid_ff  <= 1'b0;
         found_ff     <= 1'b0;
         last_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rd_valid_ff  <= rd_valid_in;
         found_ff     <= found_in;
         last_ff      <= last_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      mode_ff        <= mode_in;
      amt_ff         <= amt_in;
      idx_ff         <= idx_in;
      cnt_ff         <= cnt_in;
      idx_d_ff       <= idx_d_in;
      best_ff        <= best_in;
      pick_ff        <= pick_in;
      rsp_granted_ff <= rsp_granted_in;
      rsp_slot_ff    <= rsp_slot_in;
      rsp_left_ff    <= rsp_left_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_granted_ff;
   assign rsp_tdata  = {{(RSP_DATA_BITS - SLOT_BITS - AMT_BITS){1'b0}},
                        rsp_left_ff, rsp_slot_ff};

endmodule
`default_nettype wire

// File: tb/sv/fixed_partition_fit_allocator_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Fixed partition fit allocator testbench
// Loads every partition, then runs a short directed table and a long random
// mix of loads, reserved operation codes and first, next, best and worst fit
// requests. A shadow copy of the partition table predicts each grant.
// Responses are checked field by field as they come out. Both channels stall
// at random, and the response side is held off for a long stretch once.
// ----------------------------------------------------------------------------
module fixed_partition_fit_allocator_tb;
   import fpfa_pkg::*;

   localparam int           ALLOC_CYCLES    = NUM_PARTS + 3;
   localparam int           ITEMS_PER_PHASE = 160;
   localparam int           HOLD_CYCLES     = 400;
   localparam logic [2:0]   OP_RSVD_FIRST   = 3'd5;
   localparam logic [2:0]   OP_RSVD_LAST    = 3'd7;
   localparam int           PAD_BITS        = REQ_DATA_BITS - AMT_BITS - SLOT_BITS;

   typedef struct packed {
      logic     granted;
      idx_type  slot;
      size_type leftover;
   } grant_type;

   typedef struct packed {
      logic [OP_BITS-1:0] op;
      idx_type            slot;
      size_type           amount;
      logic               typed;
      grant_type          want;
   } stim_row_type;

   logic                      clock;
   logic                      reset;
   logic                      req_tvalid;
   logic                      req_tready;
   logic [OP_BITS-1:0]        req_tuser;
   logic [REQ_DATA_BITS-1:0]  req_tdata;
   logic                      rsp_tvalid;
   logic                      rsp_tready;
   logic                      rsp_tuser;
   logic [RSP_DATA_BITS-1:0]  rsp_tdata;

   // Shadow of the partition table.
   size_type    shadow_size [NUM_PARTS];
   bit          shadow_used [NUM_PARTS];
   int unsigned shadow_last;

   grant_type    grant_q [$];
   stim_row_type dir_rows [$];
   int           errors;
   int unsigned  send_gap_pct;
   int unsigned  stall_pct;
   bit           hold_pending;
   int           hold_left;
   grant_type    got;
   grant_type    want;

   fixed_partition_fit_allocator u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tuser  (rsp_tuser),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // Applies one transaction to the shadow table. Returns 1 when the
   // transaction yields a response, which is then placed in g.
   function automatic bit fit_partition(input logic [OP_BITS-1:0] op, input idx_type slot,
                                        input size_type amt, output grant_type g);
      bit          found;
      int unsigned pick;
      int unsigned idx;
      size_type    rem;
      size_type    bestv;
      found = 1'b0;
      pick  = 0;
      bestv = '0;
      g     = '0;
      if (op == OP_LOAD) begin
         shadow_size[slot] = amt;
         shadow_used[slot] = 1'b0;
         return 1'b0;
      end
      if (op > OP_WORST)
         return 1'b0;
      for (int k = 0; k < NUM_PARTS; k++) begin
         idx = (op == OP_NEXT) ? (shadow_last + k) % NUM_PARTS : k;
         if (!shadow_used[idx] && shadow_size[idx] >= amt) begin
            rem = shadow_size[idx] - amt;
            if (op == OP_FIRST || op == OP_NEXT) begin
               if (!found) begin
                  found = 1'b1;
                  pick  = idx;
               end
            end else if (!found || (op == OP_BEST ? rem < bestv : rem > bestv)) begin
               found = 1'b1;
               bestv = rem;
               pick  = idx;
            end
         end
      end
      if (found) begin
         shadow_used[pick] = 1'b1;
         shadow_last       = pick;
         g.granted         = 1'b1;
         g.slot            = idx_type'(pick);
         g.leftover        = shadow_size[pick] - amt;
      end
      return 1'b1;
   endfunction

   function automatic size_type draw_amount();
      int unsigned r;
      r = $urandom_range(0, 15);
      if (r == 0)
         return '0;
      if (r == 1)
         return '1;
      if (r < 6)
         return size_type'($urandom);
      // Narrow range so that requests fit only some partitions and ties occur.
      return size_type'($urandom_range(0, 48));
   endfunction

   task automatic add_row(input logic [OP_BITS-1:0] op, input int unsigned slot,
                          input int unsigned amt, input int unsigned typed,
                          input int unsigned granted,
                          input int unsigned slot_exp, input int unsigned left_exp);
      stim_row_type row;
      row.op            = op;
      row.slot          = idx_type'(slot);
      row.amount        = size_type'(amt);
      row.typed         = (typed != 0);
      row.want.granted  = (granted != 0);
      row.want.slot     = idx_type'(slot_exp);
      row.want.leftover = size_type'(left_exp);
      dir_rows.push_back(row);
   endtask

   // Offers one transaction, starting at a falling edge and returning at the
   // falling edge after it has been taken.
   task automatic offer_item(input logic [OP_BITS-1:0] op, input idx_type slot,
                             input size_type amt, input bit typed, input grant_type exp_g);
      grant_type g;
      bit        gives;
      while (send_gap_pct != 0 && $urandom_range(0, 99) < send_gap_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {{PAD_BITS{1'b0}}, amt, slot};
      @(posedge clock);
      while (!req_tready)
         @(posedge clock);
      gives = fit_partition(op, slot, amt, g);
      if (gives)
         grant_q.push_back(typed ? exp_g : g);
      @(negedge clock);
   endtask

   task automatic report_field(input string name, input int unsigned exp_v,
                               input int unsigned act_v);
      if (exp_v != act_v) begin
         $display("%0t: %s expected %0d actual %0d", $time, name, exp_v, act_v);
         errors++;
      end
   endtask

   // Response side: random stalls, or a long hold-off when one is asked for.
   always @(negedge clock) begin
      if (hold_left > 0) begin
         rsp_tready <= 1'b0;
         hold_left--;
      end else if (hold_pending) begin
         hold_pending = 1'b0;
         hold_left    = HOLD_CYCLES - 1;
         rsp_tready  <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(0, 99) >= stall_pct);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.granted  = rsp_tuser;
         got.slot     = rsp_tdata[SLOT_BITS-1:0];
         got.leftover = rsp_tdata[SLOT_BITS +: AMT_BITS];
         if (grant_q.size() == 0) begin
            $display("%0t: response with none outstanding, granted %0d slot %0d leftover %0d",
                     $time, got.granted, got.slot, got.leftover);
            errors++;
         end else begin
            want = grant_q.pop_front();
            report_field("granted", 32'(want.granted), 32'(got.granted));
            report_field("chosen_slot", 32'(want.slot), 32'(got.slot));
            report_field("leftover", 32'(want.leftover), 32'(got.leftover));
         end
      end
   end

   initial begin
      #2_000_000;
      $display("fixed_partition_fit_allocator: mismatch");
      $finish;
   end

   initial begin
      int unsigned gap_by_phase   [4];
      int unsigned stall_by_phase [4];
      int          counted;
      int          waited;
      int unsigned pick;
      logic [OP_BITS-1:0] op;
      gap_by_phase   = '{0, 48, 0, 36};
      stall_by_phase = '{0, 0, 48, 36};
      errors       = 0;
      shadow_last  = 0;
      send_gap_pct = 0;
      stall_pct    = 0;
      hold_pending = 1'b0;
      hold_left    = 0;
      req_tvalid   = 1'b0;
      req_tuser    = '0;
      req_tdata    = '0;
      reset        = 1'b1;
      foreach (shadow_used[i]) begin
         shadow_used[i] = 1'b0;
         shadow_size[i] = '0;
      end

      // Every partition is loaded before the first request.
      add_row(OP_LOAD, 0, 0, 0, 0, 0, 0);
      add_row(OP_LOAD, 1, 65535, 0, 0, 0, 0);
      add_row(OP_LOAD, 2, 100, 0, 0, 0, 0);
      add_row(OP_LOAD, 3, 50, 0, 0, 0, 0);
      add_row(OP_LOAD, 4, 100, 0, 0, 0, 0);
      add_row(OP_LOAD, 5, 200, 0, 0, 0, 0);
      add_row(OP_LOAD, 6, 200, 0, 0, 0, 0);
      add_row(OP_LOAD, 7, 30, 0, 0, 0, 0);
      add_row(OP_LOAD, 8, 30, 0, 0, 0, 0);
      add_row(OP_LOAD, 9, 300, 0, 0, 0, 0);
      add_row(OP_LOAD, 10, 300, 0, 0, 0, 0);
      add_row(OP_LOAD, 11, 10, 0, 0, 0, 0);
      add_row(OP_LOAD, 12, 10, 0, 0, 0, 0);
      add_row(OP_LOAD, 13, 23130, 0, 0, 0, 0);
      add_row(OP_LOAD, 14, 65534, 0, 0, 0, 0);
      add_row(OP_LOAD, 15, 1, 0, 0, 0, 0);
      add_row(OP_FIRST, 9, 0, 1, 1, 0, 0);
      add_row(OP_FIRST, 15, 65535, 1, 1, 1, 0);
      // Nothing left that holds a full-scale request.
      add_row(OP_FIRST, 0, 65535, 1, 0, 0, 0);
      add_row(OP_RSVD_LAST, 15, 65535, 0, 0, 0, 0);
      add_row(OP_BEST, 0, 100, 0, 0, 0, 0);
      add_row(OP_WORST, 0, 1, 0, 0, 0, 0);
      add_row(OP_NEXT, 0, 0, 0, 0, 0, 0);
      add_row(OP_NEXT, 0, 0, 0, 0, 0, 0);
      // A failed next fit must leave the last grant where it was.
      add_row(OP_NEXT, 0, 65535, 1, 0, 0, 0);
      add_row(OP_NEXT, 0, 0, 0, 0, 0, 0);
      add_row(OP_LOAD, 1, 65535, 0, 0, 0, 0);
      add_row(OP_WORST, 0, 65535, 1, 1, 1, 0);

      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (dir_rows[i])
         offer_item(dir_rows[i].op, dir_rows[i].slot, dir_rows[i].amount,
                    dir_rows[i].typed, dir_rows[i].want);

      for (int phase = 0; phase < 4; phase++) begin
         send_gap_pct = gap_by_phase[phase];
         stall_pct    = stall_by_phase[phase];
         counted      = 0;
         while (counted < ITEMS_PER_PHASE) begin
            if (phase == 0 && counted == ITEMS_PER_PHASE / 2)
               hold_pending = 1'b1;
            pick = $urandom_range(0, 99);
            if (pick < 38) begin
               op = OP_LOAD;
            end else if (pick < 95) begin
               op = OP_BITS'($urandom_range(OP_FIRST, OP_WORST));
            end else begin
               op = OP_BITS'($urandom_range(OP_RSVD_FIRST, OP_RSVD_LAST));
            end
            offer_item(op, idx_type'($urandom_range(0, NUM_PARTS - 1)), draw_amount(),
                       1'b0, '0);
            if (op <= OP_WORST)
               counted++;
         end
      end
      req_tvalid <= 1'b0;

      waited = 0;
      while (grant_q.size() != 0 && waited < 20000) begin
         @(posedge clock);
         waited++;
      end
      if (grant_q.size() != 0) begin
         $display("%0t: %0d responses never arrived", $time, grant_q.size());
         errors++;
      end
      repeat (3 * ALLOC_CYCLES) @(posedge clock);
      if (errors == 0) begin
         $display("fixed_partition_fit_allocator: match");
      end else begin
         $display("fixed_partition_fit_allocator: mismatch");
      end
      $finish;
   end

endmodule

// File: sim.f
sv/fpfa_pkg.sv
sv/fpfa_store.sv
sv/fpfa_fit_unit.sv
sv/fixed_partition_fit_allocator.sv
tb/sv/fixed_partition_fit_allocator_tb.sv
